>>> rtl/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

  // Default sizes of the schedule
  localparam int DEF_MAX_CORES      = 4;
  localparam int DEF_MAX_WINDOWS    = 16;
  localparam int DEF_MAX_PARTITIONS = 16;

  // Partition entries are 5-bit two's complement; all ones marks idle
  localparam int          PART_W    = 5;
  localparam logic [4:0]  IDLE_PART = 5'h1f;

  // Configuration register indexes
  localparam logic [1:0] CFG_CORE_COUNT      = 2'd0;
  localparam logic [1:0] CFG_WINDOW_COUNT    = 2'd1;
  localparam logic [1:0] CFG_PARTITION_COUNT = 2'd2;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_STOP  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  // Verdict of the shared compare unit for one core
  typedef struct packed {
    logic differ;
    logic cur_valid;
    logic sched_valid;
  } step_t;

endpackage

>>> rtl/cyclic_partition_scheduler.sv
`timescale 1ns / 1ps

// Cyclic time-window partition scheduler. A load word (in_tuser = 1) writes one
// schedule table entry. A tick word (in_tuser = 0) applies the current window:
// the sequencer walks the active cores one at a time through a single shared
// compare unit. A core whose entry matches its current partition goes through
// the table read and compare states; a core that changes adds a start state to
// record the new partition or idle and place its start word, and a stop state
// comes first where a stop word for the old partition is due. The accept state
// before the walk and the window-done state after it complete the tick. The
// table read port is registered, so each core needs its read state before the
// compare. The input is not ready while a tick is in progress. Events leave
// through a one-word output register, so a stalled consumer holds the walk
// only where an event must be placed. The table comes out of reset as all
// idle by valid bits, with no clearing pass; configuration is to be written
// by the user only while idle, and the block itself does not enforce this.
module cyclic_partition_scheduler #(
  parameter int MAX_CORES      = cps_pkg::DEF_MAX_CORES,
  parameter int MAX_WINDOWS    = cps_pkg::DEF_MAX_WINDOWS,
  parameter int MAX_PARTITIONS = cps_pkg::DEF_MAX_PARTITIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [4:0]  cfg_wdata,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] entry_window, [5:4] entry_core,
                                  // [10:6] entry_partition, [15:11] zero
  input  logic        in_tuser,   // [0] req_type
  // Event stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] event_core, [5:2] event_partition,
                                  // [9:6] window_index, [15:10] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast   // last word of the tick
);
  import cps_pkg::*;

  localparam int DEPTH = MAX_WINDOWS * MAX_CORES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CCW   = $clog2(MAX_CORES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_STOP,
    S_START,
    S_DONE
  } state_t;

  // Input fields
  logic [3:0] in_window;
  logic [1:0] in_core;
  logic [4:0] in_part;
  assign in_window = in_tdata[3:0];
  assign in_core   = in_tdata[5:4];
  assign in_part   = in_tdata[10:6];

  // Configuration
  logic [2:0] core_count_r;
  logic [4:0] window_count_r;
  logic [4:0] partition_count_r;

  // Sequencer state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   core_r, core_nxt;
  logic [CCW-1:0]  cores_r, cores_nxt;
  logic [3:0]      win_r, win_nxt;
  logic [3:0]      wcnt_r, wcnt_nxt;
  logic [4:0]      sched_r, sched_nxt;
  step_t           flags_r, flags_nxt;
  logic [4:0]      cur_r [MAX_CORES];
  logic            cur_we;
  logic [4:0]      cur_wdata;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [1:0]  out_core_r, out_core_nxt;
  logic [3:0]  out_part_r, out_part_nxt;
  logic [3:0]  out_win_r, out_win_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic        in_acc;
  logic [4:0]  cur_sel;
  step_t       verdict;
  logic [CCW-1:0] core_inc;
  logic        core_last;
  logic [3:0]  win_start;
  logic [4:0]  win_inc;

  // Table ports
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [AW-1:0] tbl_raddr;
  logic [4:0]    tbl_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign tbl_we    = in_acc && (in_tuser == REQ_LOAD) &&
                     (32'(in_window) < MAX_WINDOWS) && (32'(in_core) < MAX_CORES);
  assign tbl_waddr = AW'(32'(in_window) * MAX_CORES + 32'(in_core));
  assign tbl_raddr = AW'(32'(win_r) * MAX_CORES + 32'(core_r));

  cps_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (in_part),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // One compare unit serves every core in turn
  assign cur_sel = cur_r[core_r];

  cps_step_unit #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_step (
    .sched           (tbl_rdata),
    .cur             (cur_sel),
    .partition_count (partition_count_r),
    .verdict         (verdict)
  );

  assign core_inc  = CCW'(core_r) + CCW'(1);
  assign core_last = (core_inc >= cores_r);
  // Counter always stays below the table size, but clamp for safety
  assign win_start = (32'(wcnt_r) >= MAX_WINDOWS) ? 4'd0 : wcnt_r;
  assign win_inc   = {1'b0, win_r} + 5'd1;

  always_comb begin
    state_nxt     = state_r;
    core_nxt      = core_r;
    cores_nxt     = cores_r;
    win_nxt       = win_r;
    wcnt_nxt      = wcnt_r;
    sched_nxt     = sched_r;
    flags_nxt     = flags_r;
    cur_we        = 1'b0;
    cur_wdata     = IDLE_PART;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_core_nxt  = out_core_r;
    out_part_nxt  = out_part_r;
    out_win_nxt   = out_win_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == REQ_TICK)) begin
          // Latch the window and the clamped core count for this tick
          win_nxt  = win_start;
          core_nxt = '0;
          if (32'(core_count_r) > MAX_CORES) begin
            cores_nxt = CCW'(MAX_CORES);
          end else begin
            cores_nxt = CCW'(core_count_r);
          end
          if (core_count_r == 3'd0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        sched_nxt = tbl_rdata;
        flags_nxt = verdict;
        if (!verdict.differ) begin
          // Core already runs its scheduled partition: advance
          if (core_last) begin
            state_nxt = S_DONE;
          end else begin
            core_nxt  = core_r + CW'(1);
            state_nxt = S_READ;
          end
        end else if (verdict.cur_valid) begin
          state_nxt = S_STOP;
        end else begin
          state_nxt = S_START;
        end
      end
      S_STOP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = EV_STOP;
          out_core_nxt  = 2'(core_r);
          out_part_nxt  = cur_sel[3:0];
          out_win_nxt   = win_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_START;
        end
      end
      S_START: begin
        if (!flags_r.sched_valid || out_free) begin
          cur_we = 1'b1;
          if (flags_r.sched_valid) begin
            cur_wdata     = sched_r;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = EV_START;
            out_core_nxt  = 2'(core_r);
            out_part_nxt  = sched_r[3:0];
            out_win_nxt   = win_r;
            out_last_nxt  = 1'b0;
          end
          if (core_last) begin
            state_nxt = S_DONE;
          end else begin
            core_nxt  = core_r + CW'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = EV_DONE;
          out_core_nxt  = 2'd0;
          out_part_nxt  = 4'd0;
          out_win_nxt   = win_r;
          out_last_nxt  = 1'b1;
          // Advance the window counter, wrapping at the window count
          if ((win_inc >= window_count_r) || (32'(win_inc) >= MAX_WINDOWS)) begin
            wcnt_nxt = 4'd0;
          end else begin
            wcnt_nxt = win_inc[3:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      wcnt_r            <= 4'd0;
      out_valid_r       <= 1'b0;
      core_count_r      <= 3'd1;
      window_count_r    <= 5'd1;
      partition_count_r <= 5'd0;
      for (int i = 0; i < MAX_CORES; i++) begin
        cur_r[i] <= IDLE_PART;
      end
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cur_we) begin
        cur_r[core_r] <= cur_wdata;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CORE_COUNT:      core_count_r      <= cfg_wdata[2:0];
          CFG_WINDOW_COUNT:    window_count_r    <= cfg_wdata;
          CFG_PARTITION_COUNT: partition_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // Payload, no reset
    core_r     <= core_nxt;
    cores_r    <= cores_nxt;
    win_r      <= win_nxt;
    sched_r    <= sched_nxt;
    flags_r    <= flags_nxt;
    out_kind_r <= out_kind_nxt;
    out_core_r <= out_core_nxt;
    out_part_r <= out_part_nxt;
    out_win_r  <= out_win_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_win_r, out_part_r, out_core_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/cps_table.sv
`timescale 1ns / 1ps

module cps_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cps_pkg::PART_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [cps_pkg::PART_W-1:0] rd_data
);
  import cps_pkg::*;

  logic [PART_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [PART_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Valid bits: an entry never written reads as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : IDLE_PART;

endmodule

>>> rtl/cps_step_unit.sv
`timescale 1ns / 1ps

module cps_step_unit #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic [cps_pkg::PART_W-1:0] sched,
  input  logic [cps_pkg::PART_W-1:0] cur,
  input  logic [4:0]                 partition_count,
  output cps_pkg::step_t             verdict
);
  import cps_pkg::*;

  function automatic logic part_valid(input logic [PART_W-1:0] p,
                                      input logic [4:0] cnt);
    logic ok;
    ok = !p[PART_W-1] && ({1'b0, p[PART_W-2:0]} < cnt) &&
         (32'(p[PART_W-2:0]) < MAX_PARTITIONS);
    return ok;
  endfunction

  // Compare raw values; validity against the current partition count
  always_comb begin
    verdict.differ      = (sched != cur);
    verdict.cur_valid   = part_valid(cur, partition_count);
    verdict.sched_valid = part_valid(sched, partition_count);
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cps_pkg::*;

  localparam int IDLE_CYCLES = 30;      // longer than a tick walk with no stalls
  localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 34;

  // One request word as the driver sees it
  typedef struct packed {
    logic       kind;
    logic [3:0] win;
    logic [1:0] core;
    logic [4:0] part;
  } sched_req_t;

  // One event word as the checker sees it
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] core;
    logic [3:0] part;
    logic [3:0] win;
    logic       last;
  } sched_evt_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [4:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [3:0] entry_window, [5:4] entry_core,
                                  // [10:6] entry_partition, [15:11] zero
  logic        in_tuser   = 1'b0; // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [1:0] event_core, [5:2] event_partition,
                                  // [9:6] window_index, [15:10] zero
  logic [1:0]  out_tuser;         // [1:0] event_kind
  logic        out_tlast;

  cyclic_partition_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting for the driver, event words waiting for the block
  sched_req_t req_q[$];
  sched_evt_t evt_q[$];

  // Shadow of the scheduler state and its registers
  logic signed [4:0] sched_mem [DEF_MAX_WINDOWS*DEF_MAX_CORES];
  logic signed [4:0] cur_part  [DEF_MAX_CORES];
  logic [3:0]        win_ctr;
  logic [2:0]        core_cnt;
  logic [4:0]        win_cnt;
  logic [4:0]        part_cnt;

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  int   err_cnt  = 0;
  int   cycles   = 0;
  int   in_gap   = 0;
  int   out_stall = 0;
  bit   in_calm  = 1'b0;
  bit   out_calm = 1'b0;

  // Random phases: core_count, window_count, partition_count
  int ph_core [PHASES] = '{4, 7, 2, 0, 3, 1, 4};
  int ph_win  [PHASES] = '{16, 31, 5, 0, 1, 16, 2};
  int ph_part [PHASES] = '{16, 31, 10, 0, 8, 4, 16};

  function automatic bit part_ok(input logic signed [4:0] p);
    int v;
    v = p;
    return v >= 0 && v < int'(part_cnt) && v < DEF_MAX_PARTITIONS;
  endfunction

  function automatic sched_evt_t mk_evt(input logic [1:0] kind, input int core,
                                        input int part, input int win);
    sched_evt_t e;
    e.kind = kind;
    e.core = 2'(core);
    e.part = 4'(part);
    e.win  = 4'(win);
    e.last = (kind == EV_DONE);
    return e;
  endfunction

  // Apply one accepted request to the shadow state and queue the event
  // words it must produce.
  task automatic apply_request(input sched_req_t r);
    int ncores, nwins, w, c, s, k;
    if (r.kind == REQ_LOAD) begin
      sched_mem[int'(r.win) * DEF_MAX_CORES + int'(r.core)] = r.part;
      return;
    end
    ncores = (core_cnt > DEF_MAX_CORES) ? DEF_MAX_CORES : core_cnt;
    nwins  = (win_cnt > DEF_MAX_WINDOWS) ? DEF_MAX_WINDOWS : win_cnt;
    w = win_ctr;
    for (c = 0; c < ncores; c++) begin
      s = sched_mem[w * DEF_MAX_CORES + c];
      k = cur_part[c];
      // compare raw values: an invalid entry still differs from an idle core
      if (s != k) begin
        if (part_ok(5'(k))) evt_q.push_back(mk_evt(EV_STOP, c, k, w));
        if (part_ok(5'(s))) begin
          cur_part[c] = 5'(s);
          evt_q.push_back(mk_evt(EV_START, c, s, w));
        end else begin
          cur_part[c] = IDLE_PART;
        end
      end
    end
    evt_q.push_back(mk_evt(EV_DONE, 0, 0, w));
    // advance and wrap; a lowered count sends the counter back to 0
    w++;
    if (w >= nwins || w >= DEF_MAX_WINDOWS) w = 0;
    win_ctr = 4'(w);
  endtask

  // Sample both handshakes, track configuration and check event words
  always @(posedge clk) begin : monitor
    sched_req_t r;
    sched_evt_t got, exp_w;
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst_n) begin
      // table and cores come out of reset idle, counter at window 0
      for (int i = 0; i < DEF_MAX_WINDOWS * DEF_MAX_CORES; i++) sched_mem[i] = IDLE_PART;
      for (int i = 0; i < DEF_MAX_CORES; i++) cur_part[i] = IDLE_PART;
      win_ctr  = '0;
      core_cnt = 3'd1;
      win_cnt  = 5'd1;
      part_cnt = 5'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CORE_COUNT:      core_cnt = cfg_wdata[2:0];
          CFG_WINDOW_COUNT:    win_cnt  = cfg_wdata;
          CFG_PARTITION_COUNT: part_cnt = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        r.kind = in_tuser;
        r.win  = in_tdata[3:0];
        r.core = in_tdata[5:4];
        r.part = in_tdata[10:6];
        apply_request(r);
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.core = out_tdata[1:0];
        got.part = out_tdata[5:2];
        got.win  = out_tdata[9:6];
        got.last = out_tlast;
        if (evt_q.size() == 0) begin
          if (err_cnt < 10)
            $display("[%0t] unexpected word kind=%0d core=%0d part=%0d win=%0d last=%0b",
                     $time, got.kind, got.core, got.part, got.win, got.last);
          err_cnt++;
        end else begin
          exp_w = evt_q.pop_front();
          if (got !== exp_w) begin
            if (err_cnt < 10) begin
              $display("[%0t] mismatch exp kind=%0d core=%0d part=%0d win=%0d last=%0b",
                       $time, exp_w.kind, exp_w.core, exp_w.part, exp_w.win, exp_w.last);
              $display("    got kind=%0d core=%0d part=%0d win=%0d last=%0b",
                       got.kind, got.core, got.part, got.win, got.last);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  // Request driver: hold a word until taken, then idle a drawn gap
  always @(negedge clk) begin : driver
    sched_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (req_q.size() > 0) begin
        r = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= r.kind;
        in_tdata  <= {5'b0, r.part, r.core, r.win};
        // switch now and then into a run with no gaps at all
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Event consumer: stall a drawn number of cycles after every word taken
  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      out_stall = out_calm ? 0 : $urandom_range(0, 18);
    end
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_load(input int w, input int c, input int p);
    sched_req_t r;
    r.kind = REQ_LOAD;
    r.win  = 4'(w);
    r.core = 2'(c);
    r.part = 5'(p);
    req_q.push_back(r);
  endtask

  task automatic push_tick(input int n);
    sched_req_t r;
    r.kind = REQ_TICK;
    repeat (n) begin
      r.win  = 4'($urandom_range(0, 15));
      r.core = 2'($urandom_range(0, 3));
      r.part = 5'($urandom_range(0, 31));
      req_q.push_back(r);
    end
  endtask

  // Wait until every request is taken and every event word has arrived,
  // then give a load or a late tick time to settle.
  task automatic wait_idle();
    while (req_q.size() != 0 || in_tvalid || evt_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 5'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int cores, input int wins, input int parts);
    write_reg(CFG_CORE_COUNT, cores);
    write_reg(CFG_WINDOW_COUNT, wins);
    write_reg(CFG_PARTITION_COUNT, parts);
  endtask

  // Mostly loads into reachable windows with partitions near the valid
  // range, mixed with ticks; a quarter of the fields take any value.
  task automatic queue_random(input int n, input int wins, input int parts);
    sched_req_t r;
    int hi, top;
    hi  = (wins < 1) ? 0 : ((wins > DEF_MAX_WINDOWS) ? DEF_MAX_WINDOWS - 1 : wins - 1);
    top = (parts > DEF_MAX_PARTITIONS) ? DEF_MAX_PARTITIONS : parts;
    repeat (n) begin
      r.kind = ($urandom_range(0, 4) < 2) ? REQ_TICK : REQ_LOAD;
      r.win  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, hi));
      r.core = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) r.part = 5'($urandom_range(0, 31));
      else                           r.part = 5'(int'($urandom_range(0, top)) - 1);
      req_q.push_back(r);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Tick on reset settings: one core, one window, nothing valid
    push_tick(1);
    wait_idle();

    // Start, stop, keep, idle and invalid-negative entries over three windows;
    // load the far corner of the table too
    set_config(4, 3, 16);
    push_load(0, 0, 3);   push_load(0, 1, 15); push_load(0, 2, -1); push_load(0, 3, 0);
    push_load(1, 0, 3);   push_load(1, 1, 7);  push_load(1, 2, 5);  push_load(1, 3, -16);
    push_load(15, 3, 15);
    push_tick(4);
    wait_idle();

    // Core count over the maximum, window count zero, a nonnegative entry
    // that is not valid: it re-marks the core idle on every tick
    set_config(7, 0, 10);
    push_load(0, 1, 12);
    push_tick(2);
    wait_idle();

    // Lower the window count below the counter: apply that window, then wrap
    set_config(4, 16, 16);
    push_tick(5);
    wait_idle();
    write_reg(CFG_WINDOW_COUNT, 3);
    push_tick(2);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(ph_core[ph], ph_win[ph], ph_part[ph]);
      queue_random(PHASE_ITEMS, ph_win[ph], ph_part[ph]);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
